// ----- rtl/ubd_pkg.sv -----
// Shared types and constants for the UTF-8 byte stream decoder.
// No dependencies; imported by every module of the block.
package ubd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CodeW   = 31;
  localparam int unsigned CountW  = 3;
  localparam int unsigned StatusW = 2;
  localparam int unsigned OutDataW = 40;

  localparam logic [ByteW-1:0] LeadAsciiMax = 8'h7F;
  localparam logic [ByteW-1:0] Lead2Lo = 8'hC0;
  localparam logic [ByteW-1:0] Lead2Hi = 8'hDF;
  localparam logic [ByteW-1:0] Lead3Lo = 8'hE0;
  localparam logic [ByteW-1:0] Lead3Hi = 8'hEF;
  localparam logic [ByteW-1:0] Lead4Lo = 8'hF0;
  localparam logic [ByteW-1:0] Lead4Hi = 8'hF7;
  localparam logic [ByteW-1:0] Lead5Lo = 8'hF8;
  localparam logic [ByteW-1:0] Lead5Hi = 8'hFB;
  localparam logic [ByteW-1:0] Lead6Lo = 8'hFC;
  localparam logic [ByteW-1:0] Lead6Hi = 8'hFD;
  localparam logic [ByteW-1:0] ContMask = 8'h3F;

  typedef enum logic [StatusW-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_END     = 2'd2
  } status_t;

  // Byte held in the input register, handed to the decode stage.
  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] data;
  } byte_item_t;

endpackage

// ----- rtl/utf8_byte_stream_decoder.sv -----
// UTF-8 byte stream decoder (legacy six-byte form), top level.
// The completing byte passes the input register, then the result register, to out_tvalid.
// Throughput: one byte per cycle; ready falls only when the result register is held.
// Reset: synchronous active-low rst_n clears sequence state and both valid flags.
// Depends on ubd_pkg, ubd_in_reg and ubd_decode.
module utf8_byte_stream_decoder
  import ubd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [ByteW-1:0]    in_tdata,   // [7:0] in_byte
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OutDataW-1:0] out_tdata,  // [30:0] code_point, [33:31] byte_count
  output logic [StatusW-1:0]  out_tuser   // [1:0] status
);

  byte_item_t        item;
  logic              take;
  logic [CodeW-1:0]  res_code;
  logic [CountW-1:0] res_count;
  status_t           res_status;

  ubd_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .take      (take),
    .item      (item)
  );

  ubd_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (item),
    .take       (take),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res_code   (res_code),
    .res_count  (res_count),
    .res_status (res_status)
  );

  assign out_tdata = {{(OutDataW-CodeW-CountW){1'b0}}, res_count, res_code};
  assign out_tuser = res_status;

endmodule

// ----- rtl/ubd_in_reg.sv -----
// Input register of the UTF-8 decoder: captures one byte per transfer.
// Depends on ubd_pkg.
module ubd_in_reg
  import ubd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [ByteW-1:0] in_tdata,   // [7:0] in_byte
  input  logic             take,
  output byte_item_t       item
);

  logic             valid_r;
  logic             valid_nxt;
  logic [ByteW-1:0] data_r;
  logic             load;

  assign in_tready = !valid_r || take;
  assign load      = in_tvalid && in_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= in_tdata;
    end
  end

  assign item.valid = valid_r;
  assign item.data  = data_r;

endmodule

// ----- rtl/ubd_decode.sv -----
// Decode stage: sequence state, lead/continuation logic and result register.
// Depends on ubd_pkg.
module ubd_decode
  import ubd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  byte_item_t        item,
  output logic              take,
  output logic              res_valid,
  input  logic              res_ready,
  output logic [CodeW-1:0]  res_code,
  output logic [CountW-1:0] res_count,
  output status_t           res_status
);

  logic [CountW-1:0] bytes_left_r, bytes_left_nxt;
  logic [CodeW-1:0]  code_accum_r, code_accum_nxt;
  logic [CountW-1:0] seq_length_r, seq_length_nxt;

  logic              out_v_r, out_v_nxt;
  logic [CodeW-1:0]  code_r;
  logic [CountW-1:0] count_r;
  status_t           status_r;

  logic              emit;
  logic [CodeW-1:0]  emit_code;
  logic [CountW-1:0] emit_count;
  status_t           emit_status;
  logic [CountW-1:0] lead_len;
  logic [ByteW-1:0]  lead_mask;
  logic [ByteW-1:0]  b;

  assign b    = item.data;
  assign take = item.valid && (!out_v_r || res_ready);

  always_comb begin
    lead_len  = '0;
    lead_mask = '0;
    if (b >= Lead2Lo && b <= Lead2Hi) begin
      lead_len  = 3'd2;
      lead_mask = 8'h1F;
    end else if (b >= Lead3Lo && b <= Lead3Hi) begin
      lead_len  = 3'd3;
      lead_mask = 8'h0F;
    end else if (b >= Lead4Lo && b <= Lead4Hi) begin
      lead_len  = 3'd4;
      lead_mask = 8'h07;
    end else if (b >= Lead5Lo && b <= Lead5Hi) begin
      lead_len  = 3'd5;
      lead_mask = 8'h03;
    end else if (b >= Lead6Lo && b <= Lead6Hi) begin
      lead_len  = 3'd6;
      lead_mask = 8'h01;
    end
  end

  always_comb begin
    bytes_left_nxt = bytes_left_r;
    code_accum_nxt = code_accum_r;
    seq_length_nxt = seq_length_r;
    emit           = 1'b0;
    emit_code      = '0;
    emit_count     = '0;
    emit_status    = ST_OK;
    if (bytes_left_r != '0) begin
      code_accum_nxt = {code_accum_r[CodeW-7:0], b[5:0] & ContMask[5:0]};
      bytes_left_nxt = bytes_left_r - 3'd1;
      if (bytes_left_nxt == '0) begin
        emit       = 1'b1;
        emit_code  = code_accum_nxt;
        emit_count = seq_length_r;
      end
    end else if (b == '0) begin
      emit        = 1'b1;
      emit_status = ST_END;
    end else if (b <= LeadAsciiMax) begin
      emit       = 1'b1;
      emit_code  = {{(CodeW-ByteW){1'b0}}, b};
      emit_count = 3'd1;
    end else if (lead_len != '0) begin
      code_accum_nxt = {{(CodeW-ByteW){1'b0}}, b & lead_mask};
      seq_length_nxt = lead_len;
      bytes_left_nxt = lead_len - 3'd1;
    end else begin
      emit        = 1'b1;
      emit_status = ST_INVALID;
    end
  end

  always_comb begin
    out_v_nxt = out_v_r;
    if (take && emit) begin
      out_v_nxt = 1'b1;
    end else if (res_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_left_r <= '0;
      code_accum_r <= '0;
      seq_length_r <= '0;
      out_v_r      <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
      if (take) begin
        bytes_left_r <= bytes_left_nxt;
        code_accum_r <= code_accum_nxt;
        seq_length_r <= seq_length_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      code_r   <= emit_code;
      count_r  <= emit_count;
      status_r <= emit_status;
    end
  end

  assign res_valid  = out_v_r;
  assign res_code   = code_r;
  assign res_count  = count_r;
  assign res_status = status_r;

`ifndef NO_ASSERTIONS
  a_left_range: assert property (@(posedge clk) disable iff (!rst_n)
    bytes_left_r <= 3'd5)
    else $error("bytes_left out of range");

  a_left_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    bytes_left_r != '0 |-> (seq_length_r >= 3'd2 && bytes_left_r < seq_length_r))
    else $error("sequence state inconsistent");

  a_ok_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && status_r == ST_OK |-> count_r != '0)
    else $error("ok result with zero byte count");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && status_r != ST_OK |-> (count_r == '0 && code_r == '0))
    else $error("non-ok result carries data");
`endif

endmodule

// ----- sim/utf8_byte_stream_decoder_tb.sv -----
// Self-checking testbench for utf8_byte_stream_decoder: byte stream in, decoded chars out.
// Holds its own decoder model and scoreboard; depends on ubd_pkg and the RTL top only.
`timescale 1ns / 1ps

module utf8_byte_stream_decoder_tb;
  import ubd_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int BytesPerPhase = 350;
  localparam int HoldOffCycles = 300;

  typedef struct packed {
    logic [CodeW-1:0]  code_point;
    logic [CountW-1:0] byte_count;
    status_t           status;
  } char_result_t;

  class utf8_char_tracker;
    logic [2:0]       bytes_left;
    logic [CodeW-1:0] code_accum;
    logic [2:0]       seq_length;
    char_result_t     pending_chars[$];
    int               errors;
    int               ok_seen;
    int               invalid_seen;
    int               end_seen;

    function new();
      bytes_left = '0;
      code_accum = '0;
      seq_length = '0;
      errors = 0;
      ok_seen = 0;
      invalid_seen = 0;
      end_seen = 0;
    endfunction

    function void push_char(logic [CodeW-1:0] cp, logic [CountW-1:0] cnt, status_t st);
      char_result_t r;
      r.code_point = cp;
      r.byte_count = cnt;
      r.status = st;
      pending_chars = {pending_chars, r};
    endfunction

    function void note_byte(logic [ByteW-1:0] b);
      logic [ByteW-1:0] cont;
      logic [2:0]       len;
      cont = b & ContMask;
      if (bytes_left != 0) begin
        code_accum = {code_accum[CodeW-7:0], cont[5:0]};
        bytes_left = bytes_left - 3'd1;
        if (bytes_left == 0) push_char(code_accum, seq_length, ST_OK);
        return;
      end
      if (b == '0) begin
        push_char('0, '0, ST_END);
        return;
      end
      if (b <= LeadAsciiMax) begin
        push_char(CodeW'(b), 3'd1, ST_OK);
        return;
      end
      if (b >= Lead2Lo && b <= Lead2Hi) len = 3'd2;
      else if (b >= Lead3Lo && b <= Lead3Hi) len = 3'd3;
      else if (b >= Lead4Lo && b <= Lead4Hi) len = 3'd4;
      else if (b >= Lead5Lo && b <= Lead5Hi) len = 3'd5;
      else if (b >= Lead6Lo && b <= Lead6Hi) len = 3'd6;
      else begin
        push_char('0, '0, ST_INVALID);
        return;
      end
      code_accum = CodeW'(b & (8'hFF >> (len + 3'd1)));
      seq_length = len;
      bytes_left = len - 3'd1;
    endfunction

    function void check_result(logic [OutDataW-1:0] tdata, logic [StatusW-1:0] tuser);
      char_result_t exp_char;
      if (pending_chars.size() == 0) begin
        $error("unexpected result: tdata %h tuser %h", tdata, tuser);
        errors++;
        return;
      end
      exp_char = pending_chars.pop_front();
      if (tdata[CodeW-1:0] !== exp_char.code_point) begin
        $error("code_point: expected %h, actual %h", exp_char.code_point, tdata[CodeW-1:0]);
        errors++;
      end
      if (tdata[CodeW+CountW-1:CodeW] !== exp_char.byte_count) begin
        $error("byte_count: expected %0d, actual %0d", exp_char.byte_count,
               tdata[CodeW+CountW-1:CodeW]);
        errors++;
      end
      if (tuser !== exp_char.status) begin
        $error("status: expected %0d, actual %0d", exp_char.status, tuser);
        errors++;
      end
      if (tdata[OutDataW-1:CodeW+CountW] !== '0) begin
        $error("tdata padding: expected 0, actual %h", tdata[OutDataW-1:CodeW+CountW]);
        errors++;
      end
      case (exp_char.status)
        ST_OK:      ok_seen++;
        ST_INVALID: invalid_seen++;
        default:    end_seen++;
      endcase
    endfunction

    function int pending();
      return pending_chars.size();
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [ByteW-1:0]    in_tdata;
  logic                out_tvalid;
  logic                out_tready;
  logic [OutDataW-1:0] out_tdata;
  logic [StatusW-1:0]  out_tuser;

  utf8_char_tracker tracker;
  int src_idle_pct;
  int dst_stall_pct;
  int hold_req;
  int hold_left;
  int idle_cycles;
  int bytes_sent;

  utf8_byte_stream_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // result side: check, watchdog, ready with stalls and long hold-off
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) tracker.check_result(out_tdata, out_tuser);
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WatchdogLimit) begin
      $display("timeout: no transfer for %0d cycles", idle_cycles);
      $display("FAIL");
      $finish;
    end else begin
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= dst_stall_pct);
      end
    end
  end

  task automatic send_byte(input logic [ByteW-1:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    do @(posedge clk); while (!in_tready);
    tracker.note_byte(b);
    bytes_sent++;
  endtask

  task automatic send_random_unit();
    int pick;
    int len;
    int conts;
    logic [ByteW-1:0] lead;
    pick = $urandom_range(99);
    if (pick < 15) begin
      send_byte(ByteW'($urandom_range(255)));
      return;
    end
    len = $urandom_range(6, 1);
    case (len)
      1:       lead = ByteW'($urandom_range(LeadAsciiMax, 1));
      2:       lead = ByteW'($urandom_range(Lead2Hi, Lead2Lo));
      3:       lead = ByteW'($urandom_range(Lead3Hi, Lead3Lo));
      4:       lead = ByteW'($urandom_range(Lead4Hi, Lead4Lo));
      5:       lead = ByteW'($urandom_range(Lead5Hi, Lead5Lo));
      default: lead = ByteW'($urandom_range(Lead6Hi, Lead6Lo));
    endcase
    send_byte(lead);
    // arbitrary trailing bytes, up to the full count, or else proper continuations
    if (pick < 25) begin
      conts = $urandom_range(len - 1, 0);
      repeat (conts) send_byte(ByteW'($urandom_range(255)));
    end else begin
      repeat (len - 1) send_byte({2'b10, 6'($urandom_range(63))});
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
  endtask

  initial begin
    int src_pct[4];
    int dst_pct[4];
    logic [ByteW-1:0] directed[$];
    tracker = new();
    src_pct = '{0, 79, 0, 30};
    dst_pct = '{0, 0, 79, 30};
    src_idle_pct = 0;
    dst_stall_pct = 0;
    hold_req = 0;
    hold_left = 0;
    idle_cycles = 0;
    bytes_sent = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // end marker, ASCII bounds, invalid leads, overlong 2-byte, 5-byte with
    // zero and all-ones continuations, max 4-byte lead, max 6-byte value
    directed = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hBF, 8'hFE, 8'hFF,
                 8'hC0, 8'h80,
                 8'hF8, 8'h00, 8'hFF, 8'h80, 8'h40,
                 8'hF7, 8'hBF, 8'hBF, 8'hBF,
                 8'hFD, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    foreach (directed[i]) send_byte(directed[i]);
    drain();

    for (int p = 0; p < 4; p++) begin
      src_idle_pct = src_pct[p];
      dst_stall_pct = dst_pct[p];
      if (p == 0) hold_req = HoldOffCycles;
      bytes_sent = 0;
      while (bytes_sent < BytesPerPhase) send_random_unit();
      drain();
    end

    repeat (8) @(posedge clk);
    if (tracker.pending() != 0) begin
      $error("%0d expected results never arrived", tracker.pending());
      tracker.errors++;
    end
    $display("Checked %0d ok, %0d invalid-lead and %0d end-of-text results",
             tracker.ok_seen, tracker.invalid_seen, tracker.end_seen);
    $display("across directed bytes, 1-6 byte sequences, noise and four flow-control phases");
    if (tracker.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
